// ===== rtl/wsdt_pkg.sv =====
`default_nettype none

package wsdt_pkg;

    // widths of the run counter and the distance accumulator
    localparam int DIST_WIDTH = 48;
    localparam int RUN_WIDTH = 40;

    // fixed field widths
    localparam int PULSE_WIDTH = 20;
    localparam int IVL_WIDTH = 24;
    localparam int DPP_WIDTH = 20;
    localparam int IVL_UM_WIDTH = PULSE_WIDTH + DPP_WIDTH;
    localparam int SPEED_WIDTH = 16;
    localparam int TOT_WIDTH = 48;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 24;

    // scaling by 1000 adds ten bits
    localparam int SCALE_BITS = 10;

    // derived widths
    localparam int WIDE_WIDTH = (DIST_WIDTH > IVL_UM_WIDTH) ? DIST_WIDTH : IVL_UM_WIDTH;
    localparam int SUM_WIDTH = WIDE_WIDTH + 1;
    localparam int NUM_WIDTH = WIDE_WIDTH + SCALE_BITS;
    localparam int DEN_WIDTH = (RUN_WIDTH > IVL_WIDTH) ? RUN_WIDTH : IVL_WIDTH;
    localparam int REM_WIDTH = DEN_WIDTH + 1;
    localparam int CMP_WIDTH =
        (NUM_WIDTH > DEN_WIDTH + SPEED_WIDTH) ? NUM_WIDTH : DEN_WIDTH + SPEED_WIDTH;
    localparam int TOT_CMP_WIDTH = (DIST_WIDTH > TOT_WIDTH) ? DIST_WIDTH : TOT_WIDTH;
    localparam int DIV_STEPS = SPEED_WIDTH;
    localparam int CNT_WIDTH = $clog2(DIV_STEPS + 1);

    typedef logic [PULSE_WIDTH-1:0]     pulses_t;
    typedef logic [IVL_WIDTH-1:0]       ivl_t;
    typedef logic [DPP_WIDTH-1:0]       dpp_t;
    typedef logic [IVL_UM_WIDTH-1:0]    ivl_um_t;
    typedef logic [RUN_WIDTH-1:0]       run_t;
    typedef logic [DIST_WIDTH-1:0]      dist_t;
    typedef logic [SUM_WIDTH-1:0]       sum_t;
    typedef logic [NUM_WIDTH-1:0]       num_t;
    typedef logic [DEN_WIDTH-1:0]       den_t;
    typedef logic [REM_WIDTH-1:0]       rem_t;
    typedef logic [CMP_WIDTH-1:0]       cmp_t;
    typedef logic [SPEED_WIDTH-1:0]     speed_t;
    typedef logic [TOT_WIDTH-1:0]       tot_t;
    typedef logic [TOT_CMP_WIDTH-1:0]   tot_cmp_t;
    typedef logic [CNT_WIDTH-1:0]       cnt_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_INTERVAL_TICKS = 1'd0;
    localparam cfg_index_t REG_DIST_PER_PULSE = 1'd1;

    // reset values and limits
    localparam ivl_t INTERVAL_TICKS_RESET = 24'd200000;
    localparam dpp_t DIST_PER_PULSE_RESET = 20'd204204;
    localparam pulses_t PULSE_MAX = '1;
    localparam ivl_t IVL_MAX = '1;
    localparam run_t RUN_MAX = '1;
    localparam dist_t DIST_MAX = '1;
    localparam tot_t TOT_MAX = '1;
    localparam speed_t SPEED_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic add;
        logic scale_hi;
        logic scale_lo;
        logic sel_avg;
        logic div_start;
        logic store_cur;
        logic store_avg;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/wsdt_if.sv =====
`default_nettype none

// tick item channel
interface wsdt_tick_if;
    logic valid;
    logic ready;
    logic pulse;
    logic clear_run;

    modport source (output valid, output pulse, output clear_run, input ready);
    modport sink (input valid, input pulse, input clear_run, output ready);
endinterface

// result item channel
interface wsdt_result_if;
    logic                   valid;
    logic                   ready;
    wsdt_pkg::speed_t       current_speed_mms;
    wsdt_pkg::speed_t       average_speed_mms;
    wsdt_pkg::tot_t         total_distance_um;

    modport source (output valid, output current_speed_mms, output average_speed_mms,
                    output total_distance_um, input ready);
    modport sink (input valid, input current_speed_mms, input average_speed_mms,
                  input total_distance_um, output ready);
endinterface

// configuration write channel
interface wsdt_cfg_if;
    logic                   valid;
    logic                   ready;
    wsdt_pkg::cfg_index_t   index;
    wsdt_pkg::cfg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsdt_div.sv =====
`default_nettype none

// saturating divider, one quotient bit per cycle
module wsdt_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire wsdt_pkg::num_t     num,
    input  wire wsdt_pkg::den_t     den,
    output logic                    busy,
    output wsdt_pkg::speed_t        quot
);

    logic                   busy_reg, busy_next;
    wsdt_pkg::cnt_t         cnt_reg, cnt_next;
    wsdt_pkg::rem_t         rem_reg, rem_next;
    wsdt_pkg::den_t         den_reg, den_next;
    wsdt_pkg::speed_t       low_reg, low_next;
    wsdt_pkg::speed_t       quot_reg, quot_next;

    logic                   sat;
    wsdt_pkg::rem_t         rem_shift;
    logic                   fits;

    // quotient too large for sixteen bits
    assign sat = wsdt_pkg::cmp_t'(num) >=
                 (wsdt_pkg::cmp_t'(den) << wsdt_pkg::SPEED_WIDTH);

    // one restoring step
    assign rem_shift = {rem_reg[wsdt_pkg::REM_WIDTH-2:0], low_reg[wsdt_pkg::SPEED_WIDTH-1]};
    assign fits = rem_shift >= wsdt_pkg::rem_t'(den_reg);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        low_next = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            den_next = den;
            low_next = num[wsdt_pkg::SPEED_WIDTH-1:0];
            // upper part is below the divisor when not saturated
            rem_next = wsdt_pkg::rem_t'(num >> wsdt_pkg::SPEED_WIDTH);
            if (sat)
            begin
                quot_next = wsdt_pkg::SPEED_MAX;
                busy_next = 1'b0;
                cnt_next = '0;
            end
            else
            begin
                quot_next = '0;
                busy_next = 1'b1;
                cnt_next = wsdt_pkg::cnt_t'(wsdt_pkg::DIV_STEPS);
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_shift - wsdt_pkg::rem_t'(den_reg)) : rem_shift;
            quot_next = {quot_reg[wsdt_pkg::SPEED_WIDTH-2:0], fits};
            low_next = {low_reg[wsdt_pkg::SPEED_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            busy_next = (cnt_reg != wsdt_pkg::cnt_t'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

    // a division either runs or ends saturated at once
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg || (quot_reg == wsdt_pkg::SPEED_MAX))
        else $error("divider start left neither busy nor saturated");

endmodule

`default_nettype wire

// ===== rtl/wsdt_ctrl.sv =====
`default_nettype none

// sequencer for one tick item
module wsdt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tick_valid,
    output logic                     tick_ready,
    input  wire wsdt_pkg::status_t   sts,
    output wsdt_pkg::cmd_t           cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL       = 3'd1;
    localparam logic [2:0] S_ADD       = 3'd2;
    localparam logic [2:0] S_SCALE_HI  = 3'd3;
    localparam logic [2:0] S_SCALE_LO  = 3'd4;
    localparam logic [2:0] S_DIV_START = 3'd5;
    localparam logic [2:0] S_DIV_WAIT  = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       phase_reg, phase_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        cmd.sel_avg = phase_reg;
        tick_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.hit)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                phase_next = 1'b0;
                state_next = S_SCALE_HI;
            end
            S_SCALE_HI:
            begin
                cmd.scale_hi = 1'b1;
                state_next = S_SCALE_LO;
            end
            S_SCALE_LO:
            begin
                cmd.scale_lo = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (phase_reg)
                    begin
                        cmd.store_avg = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.store_cur = 1'b1;
                        phase_next = 1'b1;
                        state_next = S_SCALE_HI;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // the divider is never restarted while it runs
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== rtl/wsdt_dp.sv =====
`default_nettype none

// counters, configuration, arithmetic and output register
module wsdt_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wsdt_pkg::cmd_t         cmd,
    output wsdt_pkg::status_t           sts,
    input  wire logic                   pulse,
    input  wire logic                   clear_run,
    input  wire logic                   cfg_write,
    input  wire wsdt_pkg::cfg_index_t   cfg_index,
    input  wire wsdt_pkg::cfg_data_t    cfg_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output wsdt_pkg::speed_t            current_speed_mms,
    output wsdt_pkg::speed_t            average_speed_mms,
    output wsdt_pkg::tot_t              total_distance_um
);

    wsdt_pkg::ivl_t     ticks_reg;
    wsdt_pkg::dpp_t     dpp_reg;
    wsdt_pkg::pulses_t  pulses_reg, pulses_next;
    wsdt_pkg::ivl_t     ivl_reg, ivl_next;
    wsdt_pkg::run_t     run_reg, run_next;
    wsdt_pkg::dist_t    total_reg, total_next;
    wsdt_pkg::ivl_um_t  ivl_um_reg;
    wsdt_pkg::num_t     num_reg;
    wsdt_pkg::speed_t   cur_reg;
    wsdt_pkg::speed_t   avg_reg;
    logic               out_valid_reg, out_valid_next;
    wsdt_pkg::speed_t   out_cur_reg;
    wsdt_pkg::speed_t   out_avg_reg;
    wsdt_pkg::tot_t     out_tot_reg;

    wsdt_pkg::pulses_t  pulses_inc;
    wsdt_pkg::ivl_t     ivl_inc;
    wsdt_pkg::run_t     run_inc;
    wsdt_pkg::sum_t     sum;
    wsdt_pkg::num_t     scale_src;
    wsdt_pkg::den_t     den;
    logic               div_busy;
    wsdt_pkg::speed_t   quot;
    wsdt_pkg::tot_t     tot_sat;

    // saturating increments for the incoming tick
    assign pulses_inc = (pulse && (pulses_reg != wsdt_pkg::PULSE_MAX))
                        ? pulses_reg + 1'b1 : pulses_reg;
    assign ivl_inc = (ivl_reg != wsdt_pkg::IVL_MAX) ? ivl_reg + 1'b1 : ivl_reg;
    assign run_inc = (run_reg != wsdt_pkg::RUN_MAX) ? run_reg + 1'b1 : run_reg;

    // interval ends on this tick
    assign sts.hit = !clear_run && (ivl_inc >= ticks_reg);
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || result_ready;

    // saturating distance sum
    assign sum = wsdt_pkg::sum_t'(total_reg) + wsdt_pkg::sum_t'(ivl_um_reg);

    // operand selection for the two speeds
    assign scale_src = cmd.sel_avg ? wsdt_pkg::num_t'(total_reg)
                                   : wsdt_pkg::num_t'(ivl_um_reg);
    assign den = cmd.sel_avg ? wsdt_pkg::den_t'(run_reg) : wsdt_pkg::den_t'(ivl_reg);

    // total clamped to the output field
    assign tot_sat = (wsdt_pkg::tot_cmp_t'(total_reg) > wsdt_pkg::tot_cmp_t'(wsdt_pkg::TOT_MAX))
                     ? wsdt_pkg::TOT_MAX : wsdt_pkg::tot_t'(total_reg);

    // counter updates
    always_comb
    begin
        pulses_next = pulses_reg;
        ivl_next = ivl_reg;
        run_next = run_reg;
        total_next = total_reg;
        if (cmd.accept)
        begin
            if (clear_run)
            begin
                pulses_next = '0;
                ivl_next = '0;
                run_next = '0;
                total_next = '0;
            end
            else
            begin
                pulses_next = pulses_inc;
                ivl_next = ivl_inc;
                run_next = run_inc;
            end
        end
        if (cmd.add)
        begin
            total_next = (sum > wsdt_pkg::sum_t'(wsdt_pkg::DIST_MAX))
                         ? wsdt_pkg::DIST_MAX : wsdt_pkg::dist_t'(sum);
        end
        if (cmd.emit)
        begin
            pulses_next = '0;
            ivl_next = '0;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= wsdt_pkg::INTERVAL_TICKS_RESET;
            dpp_reg <= wsdt_pkg::DIST_PER_PULSE_RESET;
            pulses_reg <= '0;
            ivl_reg <= '0;
            run_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    wsdt_pkg::REG_INTERVAL_TICKS: ticks_reg <= cfg_data;
                    wsdt_pkg::REG_DIST_PER_PULSE: dpp_reg <= cfg_data[wsdt_pkg::DPP_WIDTH-1:0];
                    default: ticks_reg <= ticks_reg;
                endcase
            end
            pulses_reg <= pulses_next;
            ivl_reg <= ivl_next;
            run_reg <= run_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            ivl_um_reg <= wsdt_pkg::ivl_um_t'(pulses_reg) * wsdt_pkg::ivl_um_t'(dpp_reg);
        end
        // times 1000 as (x * 992) then plus (x * 8)
        if (cmd.scale_hi)
        begin
            num_reg <= (scale_src << 10) - (scale_src << 5);
        end
        if (cmd.scale_lo)
        begin
            num_reg <= num_reg + (scale_src << 3);
        end
        if (cmd.store_cur)
        begin
            cur_reg <= quot;
        end
        if (cmd.store_avg)
        begin
            avg_reg <= (run_reg == '0) ? '0 : quot;
        end
        if (cmd.emit)
        begin
            out_cur_reg <= cur_reg;
            out_avg_reg <= avg_reg;
            out_tot_reg <= tot_sat;
        end
    end

    wsdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign result_valid = out_valid_reg;
    assign current_speed_mms = out_cur_reg;
    assign average_speed_mms = out_avg_reg;
    assign total_distance_um = out_tot_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten");

    // distance only falls on a clear
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && clear_run) |=> total_reg >= $past(total_reg))
        else $error("distance decreased without clear");

endmodule

`default_nettype wire

// ===== rtl/wheel_speed_distance_tracker.sv =====
// Wheel speed and distance tracker.
// tick channel: one item per microsecond tick, with a pulse flag (sensor falling
// edge seen) and a clear_run flag. clear_run zeroes the run and gives no result.
// result channel: one item each time the measurement interval elapses, carrying
// current speed and average speed in mm/s (saturating at 65535) and the total
// distance in micrometres since the last clear.
// cfg channel: index 0 writes interval_ticks, index 1 writes distance_per_pulse_um;
// always ready, to be written only while the block is idle.
// Ticks: a tick that does not end an interval leaves the sequencer idle and ready
// for the next tick. A tick that ends an interval holds off further ticks while
// the sequencer runs one multiply, one add, then two divisions on a shared divider
// that produces one quotient bit per cycle (16 steps each, after scaling and a
// start); a division whose quotient saturates ends at once. The result then waits
// until the output register is free.
// The result sits in an output register; a stalled receiver holds it there and
// ticks keep being accepted until the next interval result is ready to load.
// Reset: counters and distance are zero, interval_ticks is 200000 and
// distance_per_pulse_um is 204204, no result is pending.
`default_nettype none

module wheel_speed_distance_tracker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wsdt_tick_if.sink       tick,
    wsdt_result_if.source   result,
    wsdt_cfg_if.sink        cfg
);

    wsdt_pkg::cmd_t     cmd;
    wsdt_pkg::status_t  sts;
    logic               tick_ready;

    assign tick.ready = tick_ready;
    assign cfg.ready = 1'b1;

    wsdt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    wsdt_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .pulse             (tick.pulse),
        .clear_run         (tick.clear_run),
        .cfg_write         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .result_valid      (result.valid),
        .result_ready      (result.ready),
        .current_speed_mms (result.current_speed_mms),
        .average_speed_mms (result.average_speed_mms),
        .total_distance_um (result.total_distance_um)
    );

endmodule

`default_nettype wire
